>>> src/assert_macros.svh
// assertion helpers used by the rtl top level
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/twabs_pkg.sv
// shared types and constants of the two-wheel anti-lock brake controller
// no dependencies
`default_nettype none

package twabs_pkg;

  localparam int SPEED_W    = 16;
  localparam int AVG_W      = 16;
  localparam int DRIVE_W    = 2;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int WINDOW_DEF = 8;

  typedef logic [CFG_W-1:0] cnt8_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  localparam cnt8_t THRESH_RST = 8'd3;
  localparam cnt8_t PULSES_RST = 8'd5;

  // actuator command codes
  localparam drive_t DRV_ACCEL = drive_t'(2'b01);
  localparam drive_t DRV_HOLD  = drive_t'(2'b00);
  localparam drive_t DRV_SLOW  = drive_t'(2'b11);
  localparam drive_t DRV_BRAKE = drive_t'(2'b10);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_PULSES    = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> src/two_wheel_abs_brake_controller.sv
// two-wheel anti-lock brake controller, top level
// depends on twabs_pkg and assert_macros.svh
//
// usage:
//   input channel (in_valid/in_ready): one beat per sensor sample pair plus
//   the brake reference. every WINDOW beats close one averaging window.
//   result channel (out_valid/out_ready): one beat per closed window with
//   both drive commands, both window averages and the anti-lock flags.
//   config port (cfg_we/cfg_index/cfg_wdata): index 0 is the equal-count
//   threshold, index 1 the pulse count; write only while the block is idle.
// pipeline: a result passes the sum register, the reciprocal-multiply average
//   register and the control/output register after the beat that closes its window.
// throughput: one input beat per cycle while in_ready is high; results at most one per cycle.
// reset: synchronous, active low; clears sums, counters and the pipeline,
//   loads threshold 3 and pulse count 5.
// stall: when out_ready is low the output register holds; the two inner
//   stages keep filling and in_ready drops only once both are full.
`default_nettype none
`include "assert_macros.svh"

module two_wheel_abs_brake_controller #(
  parameter int WINDOW = twabs_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [twabs_pkg::SPEED_W-1:0]  in_speed_wheel0,
  input  wire logic [twabs_pkg::SPEED_W-1:0]  in_speed_wheel1,
  input  wire logic [twabs_pkg::SPEED_W-1:0]  in_brake_reference,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output twabs_pkg::drive_t                   out_drive_wheel0,
  output twabs_pkg::drive_t                   out_drive_wheel1,
  output logic [twabs_pkg::AVG_W-1:0]         out_average_wheel0,
  output logic [twabs_pkg::AVG_W-1:0]         out_average_wheel1,
  output logic                                out_antilock_wheel0,
  output logic                                out_antilock_wheel1,
  input  wire logic                           cfg_we,
  input  wire logic [twabs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [twabs_pkg::CFG_W-1:0]    cfg_wdata
);
  import twabs_pkg::*;

  localparam int LOG_W  = (WINDOW > 1) ? $clog2(WINDOW) : 0;
  localparam int CNT_W  = (WINDOW > 1) ? LOG_W : 1;
  localparam int SUM_W  = SPEED_W + LOG_W;
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  // ceil(2^SHIFT / WINDOW) gives an exact floor division for SUM_W-bit sums
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
                             / longint'(WINDOW);
  localparam logic [RCP_W-1:0] RECIP_C  = RCP_W'(RECIP);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);

  // registers
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum0_r, sum1_r;
  logic               p1_v_r;
  logic [SUM_W-1:0]   p1_sum0_r, p1_sum1_r;
  logic [SPEED_W-1:0] p1_ref_r;
  logic               p2_v_r;
  logic [AVG_W-1:0]   p2_avg0_r, p2_avg1_r;
  logic [SPEED_W-1:0] p2_ref_r;
  logic               out_v_r;
  drive_t             out_drv0_r, out_drv1_r;
  logic [AVG_W-1:0]   out_avg0_r, out_avg1_r;
  logic               out_al0_r, out_al1_r;
  cnt8_t              thr_r, pulses_r;
  logic [AVG_W-1:0]   prev_r [2];
  cnt8_t              ecd_r  [2];
  cnt8_t              pl_r   [2];
  drive_t             last_r [2];

  // handshake and stage advance
  logic out_free, p2_free, p1_free, in_acc, win_end;
  assign out_free = !out_v_r || out_ready;
  assign p2_free  = !p2_v_r || out_free;
  assign p1_free  = !p1_v_r || p2_free;
  assign in_ready = p1_free;
  assign in_acc   = in_valid && in_ready;
  assign win_end  = (cnt_r == LAST_CNT);

  // window accumulation
  logic [SUM_W-1:0] sum0_nxt, sum1_nxt;
  assign sum0_nxt = sum0_r + SUM_W'(in_speed_wheel0);
  assign sum1_nxt = sum1_r + SUM_W'(in_speed_wheel1);

  // average by reciprocal multiply
  logic [PROD_W-1:0] prod0, prod1;
  assign prod0 = PROD_W'(p1_sum0_r) * PROD_W'(RECIP_C);
  assign prod1 = PROD_W'(p1_sum1_r) * PROD_W'(RECIP_C);

  // control period for both wheels
  logic [AVG_W-1:0] avg_c [2];
  logic             ref_zero;
  logic             active [2];
  logic             hit    [2];
  logic             qual   [2];
  logic             pulse_c [2];
  cnt8_t            dec_c  [2];
  cnt8_t            ecd_c  [2];
  cnt8_t            pla_c  [2];
  cnt8_t            pls_c  [2];
  cnt8_t            pln_c  [2];
  drive_t           drv_c  [2];

  assign avg_c[0] = p2_avg0_r;
  assign avg_c[1] = p2_avg1_r;
  assign ref_zero = (p2_ref_r == '0);

  always_comb begin
    // equal-average counting and arming
    for (int w = 0; w < 2; w++) begin
      active[w] = ref_zero && (avg_c[w] != '0);
      hit[w]    = active[w] && (avg_c[w] == prev_r[w]) && (pl_r[w] == '0);
      dec_c[w]  = ecd_r[w] - 8'd1;
      ecd_c[w]  = thr_r;
      pla_c[w]  = pl_r[w];
      if (hit[w]) begin
        if (dec_c[w] == '0) begin
          pla_c[w] = pulses_r;
        end else begin
          ecd_c[w] = dec_c[w];
        end
      end
      qual[w] = active[w] && ((pla_c[w] == '0) || (pla_c[w] == pulses_r));
    end
    // wheel sync
    for (int w = 0; w < 2; w++) begin
      pls_c[w] = (qual[0] && qual[1]) ? (pla_c[0] | pla_c[1]) : pla_c[w];
    end
    // drive selection
    for (int w = 0; w < 2; w++) begin
      pulse_c[w] = 1'b0;
      pln_c[w]   = pls_c[w];
      drv_c[w]   = last_r[w];
      if (pls_c[w] != '0) begin
        if (active[w]) begin
          drv_c[w]   = DRV_HOLD;
          pln_c[w]   = pls_c[w] - 8'd1;
          pulse_c[w] = 1'b1;
        end else begin
          pln_c[w] = '0;
        end
      end else if (active[w]) begin
        drv_c[w] = DRV_BRAKE;
      end else if (p2_ref_r > avg_c[w]) begin
        drv_c[w] = DRV_ACCEL;
      end else if (p2_ref_r < avg_c[w]) begin
        drv_c[w] = DRV_SLOW;
      end else begin
        drv_c[w] = DRV_HOLD;
      end
    end
  end

  // control state, config and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sum0_r   <= '0;
      sum1_r   <= '0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      thr_r    <= THRESH_RST;
      pulses_r <= PULSES_RST;
      for (int w = 0; w < 2; w++) begin
        prev_r[w] <= '0;
        ecd_r[w]  <= THRESH_RST;
        pl_r[w]   <= '0;
        last_r[w] <= DRV_HOLD;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_THRESHOLD: thr_r    <= cfg_wdata;
          REG_PULSES:    pulses_r <= cfg_wdata;
          default:       ;
        endcase
      end
      if (in_acc) begin
        if (win_end) begin
          cnt_r  <= '0;
          sum0_r <= '0;
          sum1_r <= '0;
        end else begin
          cnt_r  <= cnt_r + 1'b1;
          sum0_r <= sum0_nxt;
          sum1_r <= sum1_nxt;
        end
      end
      if (p1_free) begin
        p1_v_r <= in_acc && win_end;
      end
      if (p2_free) begin
        p2_v_r <= p1_v_r;
      end
      if (out_free) begin
        out_v_r <= p2_v_r;
      end
      if (out_free && p2_v_r) begin
        for (int w = 0; w < 2; w++) begin
          prev_r[w] <= avg_c[w];
          ecd_r[w]  <= ecd_c[w];
          pl_r[w]   <= pln_c[w];
          last_r[w] <= drv_c[w];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (p1_free && in_acc && win_end) begin
      p1_sum0_r <= sum0_nxt;
      p1_sum1_r <= sum1_nxt;
      p1_ref_r  <= in_brake_reference;
    end
    if (p2_free && p1_v_r) begin
      p2_avg0_r <= AVG_W'(prod0 >> SHIFT);
      p2_avg1_r <= AVG_W'(prod1 >> SHIFT);
      p2_ref_r  <= p1_ref_r;
    end
    if (out_free && p2_v_r) begin
      out_drv0_r <= drv_c[0];
      out_drv1_r <= drv_c[1];
      out_avg0_r <= avg_c[0];
      out_avg1_r <= avg_c[1];
      out_al0_r  <= pulse_c[0];
      out_al1_r  <= pulse_c[1];
    end
  end

  // result port
  assign out_valid           = out_v_r;
  assign out_drive_wheel0    = out_drv0_r;
  assign out_drive_wheel1    = out_drv1_r;
  assign out_average_wheel0  = out_avg0_r;
  assign out_average_wheel1  = out_avg1_r;
  assign out_antilock_wheel0 = out_al0_r;
  assign out_antilock_wheel1 = out_al1_r;

  // checks
  `ASSERT_IMPLY(a_pulse_is_hold, out_v_r && out_al0_r, out_drv0_r == DRV_HOLD, "pulse beat without hold drive")
  `ASSERT_NEXT(a_window_to_sum_stage, in_acc && win_end, p1_v_r, "closed window lost before sum stage")
  `ASSERT_NEXT(a_avg_stage_holds, p2_v_r && !out_free, p2_v_r && $stable(p2_avg0_r), "average stage changed under stall")

endmodule

`default_nettype wire

>>> sim/two_wheel_abs_brake_controller_test.sv
// self-checking testbench of the two-wheel anti-lock brake controller
// needs twabs_pkg and two_wheel_abs_brake_controller; a built-in predictor
// computes every window result, which is checked field by field at the output
`timescale 1ns / 1ps

module two_wheel_abs_brake_controller_test;
  import twabs_pkg::*;

  localparam int WIN = WINDOW_DEF;

  typedef struct packed {
    logic [SPEED_W-1:0] s0;
    logic [SPEED_W-1:0] s1;
    logic [SPEED_W-1:0] rf;
  } sample_beat_t;

  typedef struct packed {
    drive_t           d0;
    drive_t           d1;
    logic [AVG_W-1:0] a0;
    logic [AVG_W-1:0] a1;
    logic             f0;
    logic             f1;
  } drive_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SPEED_W-1:0]   in_speed_wheel0 = '0;
  logic [SPEED_W-1:0]   in_speed_wheel1 = '0;
  logic [SPEED_W-1:0]   in_brake_reference = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  drive_t               out_drive_wheel0;
  drive_t               out_drive_wheel1;
  logic [AVG_W-1:0]     out_average_wheel0;
  logic [AVG_W-1:0]     out_average_wheel1;
  logic                 out_antilock_wheel0;
  logic                 out_antilock_wheel1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  two_wheel_abs_brake_controller uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_speed_wheel0     (in_speed_wheel0),
    .in_speed_wheel1     (in_speed_wheel1),
    .in_brake_reference  (in_brake_reference),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_wheel0    (out_drive_wheel0),
    .out_drive_wheel1    (out_drive_wheel1),
    .out_average_wheel0  (out_average_wheel0),
    .out_average_wheel1  (out_average_wheel1),
    .out_antilock_wheel0 (out_antilock_wheel0),
    .out_antilock_wheel1 (out_antilock_wheel1),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pending beats, expected window results, bookkeeping
  sample_beat_t  pending_beats[$];
  drive_result_t expected_windows[$];
  sample_beat_t  next_beat;
  drive_result_t got_window;
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            gen_pos = 0;
  int            total_pushed = 0;
  int            last_a0 = 0;
  int            last_a1 = 0;

  // predictor state
  cnt8_t             thresh_reg;
  cnt8_t             pulses_reg;
  logic [21:0]       win_sum [2];
  logic [5:0]        beats_in_window;
  logic [AVG_W-1:0]  prev_avg [2];
  logic [7:0]        equal_left [2];
  logic [7:0]        pulse_left [2];
  drive_t            held_drive [2];

  task automatic clear_predictor();
    thresh_reg = THRESH_RST;
    pulses_reg = PULSES_RST;
    beats_in_window = '0;
    for (int w = 0; w < 2; w++) begin
      win_sum[w] = '0;
      prev_avg[w] = '0;
      equal_left[w] = THRESH_RST;
      pulse_left[w] = '0;
      held_drive[w] = DRV_HOLD;
    end
  endtask

  // one accepted beat: accumulate, and at the window close run a control period
  task automatic predict_beat(input logic [SPEED_W-1:0] s0, input logic [SPEED_W-1:0] s1,
                              input logic [SPEED_W-1:0] rf);
    logic [AVG_W-1:0] avg [2];
    logic             qual [2];
    logic             pulsing [2];
    logic [7:0]       both;
    drive_result_t    r;
    win_sum[0] = win_sum[0] + 22'(s0);
    win_sum[1] = win_sum[1] + 22'(s1);
    beats_in_window = beats_in_window + 6'd1;
    if (beats_in_window != 6'(WIN)) return;
    beats_in_window = '0;
    for (int w = 0; w < 2; w++) begin
      avg[w] = AVG_W'(win_sum[w] / WIN);
      win_sum[w] = '0;
    end
    // equal braking averages count down toward a pulse run
    for (int w = 0; w < 2; w++) begin
      if (avg[w] == prev_avg[w] && rf == 0 && pulse_left[w] == 0 && avg[w] != 0) begin
        equal_left[w] = equal_left[w] - 8'd1;
        if (equal_left[w] == 0) begin
          pulse_left[w] = pulses_reg;
          equal_left[w] = thresh_reg;
        end
      end else begin
        equal_left[w] = thresh_reg;
      end
    end
    // both wheels qualifying merge their counters
    for (int w = 0; w < 2; w++)
      qual[w] = rf == 0 && avg[w] != 0 && (pulse_left[w] == 0 || pulse_left[w] == pulses_reg);
    if (qual[0] && qual[1]) begin
      both = pulse_left[0] | pulse_left[1];
      pulse_left[0] = both;
      pulse_left[1] = both;
    end
    // drive command per wheel
    for (int w = 0; w < 2; w++) begin
      pulsing[w] = 1'b0;
      if (pulse_left[w] != 0) begin
        if (rf == 0 && avg[w] != 0) begin
          held_drive[w] = DRV_HOLD;
          pulse_left[w] = pulse_left[w] - 8'd1;
          pulsing[w] = 1'b1;
        end else begin
          pulse_left[w] = '0;
        end
      end else if (rf == 0 && avg[w] != 0) begin
        held_drive[w] = DRV_BRAKE;
      end else if (rf > avg[w]) begin
        held_drive[w] = DRV_ACCEL;
      end else if (rf < avg[w]) begin
        held_drive[w] = DRV_SLOW;
      end else begin
        held_drive[w] = DRV_HOLD;
      end
      prev_avg[w] = avg[w];
    end
    r.d0 = held_drive[0];
    r.d1 = held_drive[1];
    r.a0 = avg[0];
    r.a1 = avg[1];
    r.f0 = pulsing[0];
    r.f1 = pulsing[1];
    expected_windows.push_back(r);
  endtask

  // input driver: predicts each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_beat(in_speed_wheel0, in_speed_wheel1, in_brake_reference);
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_speed_wheel0 <= next_beat.s0;
          in_speed_wheel1 <= next_beat.s1;
          in_brake_reference <= next_beat.rf;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_window = '{out_drive_wheel0, out_drive_wheel1, out_average_wheel0,
                       out_average_wheel1, out_antilock_wheel0, out_antilock_wheel1};
        if (expected_windows.size() == 0) begin
          errors++;
          $display("%0t unexpected result: drive %0d/%0d avg %0d/%0d antilock %0b/%0b",
                   $time, got_window.d0, got_window.d1, got_window.a0, got_window.a1,
                   got_window.f0, got_window.f1);
        end else begin
          if (got_window !== expected_windows[0]) begin
            errors++;
            $display("%0t mismatch: expected drive %0d/%0d avg %0d/%0d antilock %0b/%0b",
                     $time, expected_windows[0].d0, expected_windows[0].d1,
                     expected_windows[0].a0, expected_windows[0].a1,
                     expected_windows[0].f0, expected_windows[0].f1);
            $display("%0t          actual drive %0d/%0d avg %0d/%0d antilock %0b/%0b",
                     $time, got_window.d0, got_window.d1, got_window.a0, got_window.a1,
                     got_window.f0, got_window.f1);
          end
          void'(expected_windows.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // stimulus helpers
  task automatic push_beat(input sample_beat_t b);
    pending_beats.push_back(b);
    gen_pos = (gen_pos + 1) % WIN;
    total_pushed++;
  endtask

  task automatic push_noise();
    sample_beat_t b;
    b.s0 = SPEED_W'($urandom_range(65535));
    b.s1 = SPEED_W'($urandom_range(65535));
    b.rf = SPEED_W'($urandom_range(65535));
    push_beat(b);
  endtask

  function automatic int pick_speed();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 65535;
      2, 3, 4: return $urandom_range(1, 300);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // one aligned window whose samples average to a0/a1, closing with rf_close
  task automatic fill_window(input int a0, input int a1, input int rf_close);
    int               av [2];
    int               span, target, acc, v;
    logic [SPEED_W-1:0] smp [2][8];
    sample_beat_t     b;
    while (gen_pos != 0) push_noise();
    av[0] = a0;
    av[1] = a1;
    for (int w = 0; w < 2; w++) begin
      case ($urandom_range(3))
        0:       span = 0;
        1:       span = 1;
        2:       span = 300;
        default: span = 65535;
      endcase
      // jittered samples, the last one restores the sum plus a truncated remainder
      target = av[w] * WIN + $urandom_range(WIN - 1);
      acc = 0;
      for (int i = 0; i < WIN - 1; i++) begin
        v = av[w] + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        smp[w][i] = SPEED_W'(v);
        acc += v;
      end
      v = target - acc;
      if (v < 0 || v > 65535) begin
        for (int i = 0; i < WIN; i++) smp[w][i] = SPEED_W'(av[w]);
      end else begin
        smp[w][WIN-1] = SPEED_W'(v);
      end
    end
    for (int i = 0; i < WIN; i++) begin
      b.s0 = smp[0][i];
      b.s1 = smp[1][i];
      if (i == WIN - 1) b.rf = SPEED_W'(rf_close);
      else b.rf = ($urandom_range(2) == 0) ? '0 : SPEED_W'($urandom_range(65535));
      push_beat(b);
    end
    last_a0 = a0;
    last_a1 = a1;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input cnt8_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: thresh_reg = val;
      REG_PULSES:    pulses_reg = val;
      default: ;
    endcase
  endtask

  // waits until every pending beat is sent and every expected window has come, then lets the pipe drain
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 3)
      0: begin
        send_idle_pct = 8;
        recv_stall_pct = 57;
      end
      1: begin
        send_idle_pct = 57;
        recv_stall_pct = 8;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // random windows: mostly braking runs of equal averages, some tracking and noise
  task automatic random_phase(input int n_beats);
    int start, a0, a1, n, rf, pick;
    start = total_pushed;
    // carry the previous run across the register change
    fill_window(last_a0, last_a1, 0);
    fill_window(last_a0, last_a1, 0);
    while (total_pushed - start < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if ($urandom_range(3) == 0) begin
          a0 = last_a0;
          a1 = last_a1;
        end else begin
          a0 = pick_speed();
          case ($urandom_range(5))
            0, 1, 2: a1 = a0;
            3, 4:    a1 = pick_speed();
            default: a1 = 0;
          endcase
        end
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(9) == 0) a0 = a0 ^ 1;
          rf = ($urandom_range(11) == 0) ? pick_speed() : 0;
          fill_window(a0, a1, rf);
        end
      end else if (pick < 85) begin
        a0 = pick_speed();
        a1 = pick_speed();
        case ($urandom_range(3))
          0:       rf = 0;
          1:       rf = a0;
          2:       rf = a1;
          default: rf = pick_speed();
        endcase
        fill_window(a0, a1, rf);
      end else begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) push_noise();
      end
    end
  endtask

  // register settings of the first five random phases, extremes and zero values included
  cnt8_t phase_thresh [6] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd3, 8'd4};
  cnt8_t phase_pulses [6] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd5, 8'd2};

  initial begin
    clear_predictor();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // directed: full-scale braking at reset settings until a pulse run arms
    for (int k = 0; k < 4; k++) fill_window(65535, 65535, 0);
    // run cancelled by a released pedal with a zero wheel, then slow/accelerate
    fill_window(32767, 0, 65535);
    fill_window(200, 50, 100);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        write_reg(REG_THRESHOLD, cnt8_t'($urandom_range(1, 6)));
        write_reg(REG_PULSES, cnt8_t'($urandom_range(1, 8)));
      end else begin
        write_reg(REG_THRESHOLD, phase_thresh[p]);
        write_reg(REG_PULSES, phase_pulses[p]);
      end
      set_idling(p);
      random_phase(245);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_windows.size() == 0) begin
      $display("two_wheel_abs_brake_controller test passed");
    end else begin
      $display("two_wheel_abs_brake_controller test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("two_wheel_abs_brake_controller test failed");
    $finish;
  end

endmodule
